### design/led64_pkg.sv
// LED-64 package: shared widths, pipeline depth, cipher tables and GF(16) helpers.
// No dependencies; imported by the round logic, the top level and the checker.
`default_nettype none

package led64_pkg;

  localparam int unsigned BlockBits  = 64;
  localparam int unsigned NibBits    = 4;
  localparam int unsigned NumNibs    = BlockBits / NibBits;
  localparam int unsigned NumRounds  = 32;
  localparam int unsigned StepRounds = 4;
  // Key-add stage plus one stage per round.
  localparam int unsigned NumStages  = NumRounds + 1;
  localparam int unsigned OccBits    = $clog2(NumStages + 1);
  localparam int unsigned RcBits     = 6;

  // Key size (64) split into nibbles for AddConstants.
  localparam logic [3:0] KsHi = 4'h4;
  localparam logic [3:0] KsLo = 4'h0;

  typedef logic [BlockBits-1:0] block_t;
  typedef logic [NibBits-1:0]   nib_t;
  typedef logic [RcBits-1:0]    rc_t;

  localparam nib_t Sbox [NumNibs] = '{
    4'hC, 4'h5, 4'h6, 4'hB, 4'h9, 4'h0, 4'hA, 4'hD,
    4'h3, 4'hE, 4'hF, 4'h8, 4'h4, 4'h7, 4'h1, 4'h2
  };

  localparam rc_t RoundConst [NumRounds] = '{
    6'h01, 6'h03, 6'h07, 6'h0F, 6'h1F, 6'h3E, 6'h3D, 6'h3B,
    6'h37, 6'h2F, 6'h1E, 6'h3C, 6'h39, 6'h33, 6'h27, 6'h0E,
    6'h1D, 6'h3A, 6'h35, 6'h2B, 6'h16, 6'h2C, 6'h18, 6'h30,
    6'h21, 6'h02, 6'h05, 6'h0B, 6'h17, 6'h2E, 6'h1C, 6'h38
  };

  // MixColumnsSerial matrix, indexed [row*4 + k].
  localparam nib_t MixMat [NumNibs] = '{
    4'h4, 4'h1, 4'h2, 4'h2,
    4'h8, 4'h6, 4'h5, 4'h6,
    4'hB, 4'hE, 4'hA, 4'h9,
    4'h2, 4'h2, 4'hF, 4'hB
  };

  // GF(16) multiply, polynomial x^4 + x + 1.
  function automatic nib_t gf16_mul(input nib_t a, input nib_t b);
    nib_t acc;
    nib_t x;
    acc = '0;
    x   = a;
    for (int i = 0; i < NibBits; i++) begin
      if (b[i]) begin
        acc = acc ^ x;
      end
      x = {x[2:0], 1'b0} ^ (x[3] ? 4'h3 : 4'h0);
    end
    return acc;
  endfunction

endpackage

`default_nettype wire

### design/led64_block_encrypt_core.sv
// LED-64 encryption core: fully unrolled 33-stage pipeline with valid/ready channels.
// Depends on led64_pkg and led64_round.
`default_nettype none

// LED-64 block encryption, one 64-bit block per transfer, key from cipher_key_i.
// The core is fully unrolled: stage 0 registers plaintext ^ key, and each of
// the following 32 stages registers one cipher round (every fourth round also
// adds the key). Throughput is one block per clock while the output is not
// stalled. Each stage carries its own valid bit and loads whenever it is empty
// or the stage after it moves, so bubbles collapse and an input transfer is
// taken while a finished block waits at the output. A stall holds every
// occupied stage; nothing is dropped or repeated. in_ready_o comes from a
// ready chain running from out_ready_i back through all 33 stage valid bits.
// cipher_key_i is written at any edge where cipher_key_we_i is high (reset
// value 0); it feeds every stage directly, so it must only change while the
// pipeline is empty. The core holds no data state between blocks.
module led64_block_encrypt_core import led64_pkg::*; (
  input  wire          clk_i,
  input  wire          rst_ni,
  // key register write
  input  wire          cipher_key_we_i,
  input  wire block_t  cipher_key_i,
  // plaintext channel
  input  wire          in_valid_i,
  output logic         in_ready_o,
  input  wire block_t  plaintext_i,
  // ciphertext channel
  output logic         out_valid_o,
  input  wire          out_ready_i,
  output block_t       ciphertext_o
);

  block_t key_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q <= '0;
    end else if (cipher_key_we_i) begin
      key_q <= cipher_key_i;
    end
  end

  logic   [NumStages-1:0] valid_q;
  logic   [NumStages-1:0] adv;      // stage may load this cycle
  logic   [NumStages-1:0] up_valid; // upstream has an item for this stage
  block_t                 state_q [NumStages];
  block_t                 state_d [NumStages];

  // ready chain: last stage frees on output transfer
  assign adv[NumStages-1] = ~valid_q[NumStages-1] | out_ready_i;
  assign up_valid[0]      = in_valid_i;
  assign state_d[0]       = plaintext_i ^ key_q;

  for (genvar s = 0; s < NumStages - 1; s++) begin : g_ready
    assign adv[s]        = ~valid_q[s] | adv[s+1];
    assign up_valid[s+1] = valid_q[s];
  end

  // round r feeds stage r+1
  for (genvar r = 0; r < NumRounds; r++) begin : g_round
    led64_round u_round (
      .state_i   (state_q[r]),
      .rc_i      (RoundConst[r]),
      .key_i     (key_q),
      .key_add_i ((r % StepRounds) == (StepRounds - 1)),
      .state_o   (state_d[r+1])
    );
  end

  for (genvar s = 0; s < NumStages; s++) begin : g_stage
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[s] <= 1'b0;
      end else if (adv[s]) begin
        valid_q[s] <= up_valid[s];
      end
    end

    // payload: no reset
    always_ff @(posedge clk_i) begin
      if (adv[s] && up_valid[s]) begin
        state_q[s] <= state_d[s];
      end
    end
  end

  assign in_ready_o   = adv[0];
  assign out_valid_o  = valid_q[NumStages-1];
  assign ciphertext_o = state_q[NumStages-1];

endmodule

`default_nettype wire

### design/led64_round.sv
// LED-64 single round: AddConstants, S-box, ShiftRows, MixColumnsSerial, optional key add.
// Purely combinational; depends on led64_pkg.
`default_nettype none

module led64_round import led64_pkg::*; (
  input  wire block_t state_i,
  input  wire rc_t    rc_i,
  input  wire block_t key_i,
  input  wire logic   key_add_i,
  output block_t      state_o
);

  nib_t s_ac  [NumNibs];
  nib_t s_sb  [NumNibs];
  nib_t s_sr  [NumNibs];
  nib_t s_mc  [NumNibs];
  nib_t hi3;
  nib_t lo3;

  assign hi3 = {1'b0, rc_i[5:3]};
  assign lo3 = {1'b0, rc_i[2:0]};

  // add constants; nibble 0 sits in the top bits
  always_comb begin
    for (int i = 0; i < NumNibs; i++) begin
      s_ac[i] = state_i[BlockBits-1-NibBits*i -: NibBits];
    end
    s_ac[0]  = s_ac[0]  ^ KsHi;
    s_ac[4]  = s_ac[4]  ^ (4'h1 ^ KsHi);
    s_ac[8]  = s_ac[8]  ^ (4'h2 ^ KsLo);
    s_ac[12] = s_ac[12] ^ (4'h3 ^ KsLo);
    s_ac[1]  = s_ac[1]  ^ hi3;
    s_ac[9]  = s_ac[9]  ^ hi3;
    s_ac[5]  = s_ac[5]  ^ lo3;
    s_ac[13] = s_ac[13] ^ lo3;
  end

  always_comb begin
    for (int i = 0; i < NumNibs; i++) begin
      s_sb[i] = Sbox[s_ac[i]];
    end
  end

  // row r rotates left by r nibbles
  always_comb begin
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        s_sr[r*4 + c] = s_sb[r*4 + ((c + r) % 4)];
      end
    end
  end

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        s_mc[r*4 + c] = gf16_mul(s_sr[c],      MixMat[r*4])
                      ^ gf16_mul(s_sr[4 + c],  MixMat[r*4 + 1])
                      ^ gf16_mul(s_sr[8 + c],  MixMat[r*4 + 2])
                      ^ gf16_mul(s_sr[12 + c], MixMat[r*4 + 3]);
      end
    end
  end

  always_comb begin
    for (int i = 0; i < NumNibs; i++) begin
      state_o[BlockBits-1-NibBits*i -: NibBits] = s_mc[i];
    end
    if (key_add_i) begin
      state_o = state_o ^ key_i;
    end
  end

endmodule

`default_nettype wire

### design/led64_chk.sv
// Port-level checker for the LED-64 core, with the bind that attaches it.
// Depends on led64_pkg and led64_block_encrypt_core.
`default_nettype none

module led64_chk import led64_pkg::*; (
  input wire         clk_i,
  input wire         rst_ni,
  input wire         in_valid_i,
  input wire         in_ready_o,
  input wire         out_valid_o,
  input wire         out_ready_i,
  input wire block_t ciphertext_o
);

  logic               in_xfer;
  logic               out_xfer;
  logic [OccBits-1:0] occ_q;
  logic [OccBits-1:0] occ_d;

  assign in_xfer  = in_valid_i & in_ready_o;
  assign out_xfer = out_valid_o & out_ready_i;

  // blocks accepted but not yet delivered
  always_comb begin
    occ_d = occ_q;
    if (in_xfer && !out_xfer) begin
      occ_d = occ_q + 1'b1;
    end else if (!in_xfer && out_xfer) begin
      occ_d = occ_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= '0;
    end else begin
      occ_q <= occ_d;
    end
  end

  a_occ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q <= OccBits'(NumStages))
    else $error("more blocks in flight than pipeline stages");

  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (occ_q != '0))
    else $error("ciphertext offered with no block in flight");

  a_ready_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!out_valid_o || out_ready_i) |-> in_ready_o)
    else $error("input stalled while output stage can drain");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(ciphertext_o)))
    else $error("stalled ciphertext changed or dropped");

endmodule

bind led64_block_encrypt_core led64_chk u_led64_chk (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_ready_o   (in_ready_o),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .ciphertext_o (ciphertext_o)
);

`default_nettype wire
